/* rtl/msh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants of the multi-stepper half-step engine
// Record layout, configuration set, item and result formats, opcodes,
// status codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package msh_pkg;

   // stepper count and record memory addressing
   localparam int STEPPERS = 32;
   localparam int ADDR_W   = (STEPPERS > 1) ? $clog2(STEPPERS) : 1;

   // coil phases per electrical cycle
   localparam int PHASES = 8;

   // heights that are a multiple of this always pass the small-move check
   localparam int SPECIAL_STEP = 100;
   // half steps in one full step
   localparam int FULL_STEP = 2;

   // divisibility test by reciprocal multiply: for a < 2**16,
   // a % SPECIAL_STEP == 0 iff (a * SPECIAL_MUL) mod 2**SPECIAL_SHIFT < SPECIAL_MUL
   localparam int SPECIAL_SHIFT = 23;
   localparam int SPECIAL_MUL   = (2**SPECIAL_SHIFT + SPECIAL_STEP - 1) / SPECIAL_STEP;

   // register port address width (seven 32-bit registers at 4*i)
   localparam int CSR_ADDR_W = 5;

   // register reset values
   localparam logic [14:0] MAX_STEPS_RST      = 15'd8000;
   localparam logic [14:0] MIN_STEP_DELTA_RST = 15'd0;
   localparam logic [1:0]  STEP_MODE_RST      = 2'd1;
   localparam logic [7:0]  TURN_WAIT_RST      = 8'd10;
   localparam logic [1:0]  BRAKE_MODE_RST     = 2'd0;
   localparam logic [7:0]  BRAKE_TICKS_RST    = 8'd10;
   localparam logic [31:0] COIL_PATTERNS_RST  = 32'd2435998920;

   // step modes
   localparam logic [1:0] MODE_HALF  = 2'd1;
   localparam logic [1:0] MODE_FULL  = 2'd2;
   localparam logic [1:0] MODE_MIXED = 2'd3;

   // brake modes
   localparam logic [1:0] BRAKE_NONE   = 2'd0;
   localparam logic [1:0] BRAKE_SMART  = 2'd1;
   localparam logic [1:0] BRAKE_ALWAYS = 2'd2;

   // held direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_FORCE = 2'd1,
      OP_STOP  = 2'd2,
      OP_TICK  = 2'd3
   } msh_op_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_HEIGHT = 3'd1,
      STATUS_STALE      = 3'd2,
      STATUS_SMALL      = 3'd3,
      STATUS_REPAIRED   = 3'd4
   } msh_status_type;

   typedef enum logic [2:0] {
      REG_MAX_STEPS      = 3'd0,
      REG_MIN_STEP_DELTA = 3'd1,
      REG_STEP_MODE      = 3'd2,
      REG_TURN_WAIT      = 3'd3,
      REG_BRAKE_MODE     = 3'd4,
      REG_BRAKE_TICKS    = 3'd5,
      REG_COIL_PATTERNS  = 3'd6
   } msh_reg_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_EXEC = 1'b1
   } msh_state_type;

   // one stepper's record as held in the state memory
   typedef struct packed {
      logic signed [15:0] position;
      logic signed [15:0] target;
      logic [2:0]         phase;
      logic [7:0]         pace_count;
      logic [7:0]         pace_reload;
      logic [7:0]         brake_count;
      logic [1:0]         held_direction;
      logic [7:0]         hold_count;
      logic [31:0]        last_revision;
   } msh_rec_type;

   typedef struct packed {
      logic [14:0] max_steps;
      logic [14:0] min_step_delta;
      logic [1:0]  step_mode;
      logic [7:0]  turn_wait_time;
      logic [1:0]  brake_mode;
      logic [7:0]  brake_ticks;
      logic [31:0] coil_patterns;
   } msh_cfg_type;

   // accepted item plus the precomputed divisibility flag
   typedef struct packed {
      msh_op_type         op;
      logic [4:0]         stepper_index;
      logic [31:0]        revision;
      logic signed [15:0] height;
      logic [7:0]         wait_ticks;
      logic               busy_req;
      logic               height_round;
   } msh_item_type;

   typedef struct packed {
      logic [4:0]     out_index;
      logic           drive;
      logic [3:0]     coil;
      msh_status_type status;
   } msh_result_type;

endpackage

/* rtl/msh_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_req_if / msh_rsp_if: item and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface msh_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [4:0]         stepper_index;
   logic signed [31:0] revision;
   logic signed [15:0] height;
   logic [7:0]         wait_ticks;
   logic               busy_req;

   modport source (
      output valid, op, stepper_index, revision, height, wait_ticks, busy_req,
      input  ready
   );
   modport sink (
      input  valid, op, stepper_index, revision, height, wait_ticks, busy_req,
      output ready
   );
endinterface

interface msh_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] out_index;
   logic       drive;
   logic [3:0] coil;
   logic [2:0] status;

   modport source (
      output valid, out_index, drive, coil, status,
      input  ready
   );
   modport sink (
      input  valid, out_index, drive, coil, status,
      output ready
   );
endinterface

/* rtl/msh_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_csr: configuration register file
// APB-style write/read of the seven engine registers at byte address 4*i.
// ----------------------------------------------------------------------------
module msh_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [msh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output msh_pkg::msh_cfg_type           cfg
);
   import msh_pkg::*;

   msh_cfg_type cfg_ff, cfg_in;
   msh_reg_type reg_sel;
   logic        wr_stb;

   assign reg_sel = msh_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_stb  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_sel)
            REG_MAX_STEPS:      cfg_in.max_steps      = pwdata[14:0];
            REG_MIN_STEP_DELTA: cfg_in.min_step_delta = pwdata[14:0];
            REG_STEP_MODE:      cfg_in.step_mode      = pwdata[1:0];
            REG_TURN_WAIT:      cfg_in.turn_wait_time = pwdata[7:0];
            REG_BRAKE_MODE:     cfg_in.brake_mode     = pwdata[1:0];
            REG_BRAKE_TICKS:    cfg_in.brake_ticks    = pwdata[7:0];
            REG_COIL_PATTERNS:  cfg_in.coil_patterns  = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_MAX_STEPS:      prdata = {17'b0, cfg_ff.max_steps};
         REG_MIN_STEP_DELTA: prdata = {17'b0, cfg_ff.min_step_delta};
         REG_STEP_MODE:      prdata = {30'b0, cfg_ff.step_mode};
         REG_TURN_WAIT:      prdata = {24'b0, cfg_ff.turn_wait_time};
         REG_BRAKE_MODE:     prdata = {30'b0, cfg_ff.brake_mode};
         REG_BRAKE_TICKS:    prdata = {24'b0, cfg_ff.brake_ticks};
         REG_COIL_PATTERNS:  prdata = cfg_ff.coil_patterns;
         default:            prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_steps      <= MAX_STEPS_RST;
         cfg_ff.min_step_delta <= MIN_STEP_DELTA_RST;
         cfg_ff.step_mode      <= STEP_MODE_RST;
         cfg_ff.turn_wait_time <= TURN_WAIT_RST;
         cfg_ff.brake_mode     <= BRAKE_MODE_RST;
         cfg_ff.brake_ticks    <= BRAKE_TICKS_RST;
         cfg_ff.coil_patterns  <= COIL_PATTERNS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/msh_state_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_state_ram: stepper record memory
// One write and one read port, registered read data. A valid bit per entry
// makes never-written records read as all zero after reset.
// ----------------------------------------------------------------------------
module msh_state_ram (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [msh_pkg::ADDR_W-1:0] rd_addr,
   input  logic                       wr_en,
   input  logic [msh_pkg::ADDR_W-1:0] wr_addr,
   input  msh_pkg::msh_rec_type       wr_data,
   output msh_pkg::msh_rec_type       rd_data
);
   import msh_pkg::*;

   msh_rec_type           mem [STEPPERS];
   msh_rec_type           rd_data_ff;
   logic [STEPPERS-1:0]   valid_ff, valid_in;
   logic                  rd_valid_ff, rd_valid_in;

   // valid bit set on first write
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   assign rd_data     = rd_valid_ff ? rd_data_ff : '0;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

endmodule

/* rtl/msh_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_update: record update logic
// Takes one item and the addressed stepper's record and forms the new
// record and the result: set, force, stop and the tick step/brake logic.
// ----------------------------------------------------------------------------
module msh_update (
   input  msh_pkg::msh_cfg_type    cfg,
   input  msh_pkg::msh_item_type   item,
   input  msh_pkg::msh_rec_type    rec_old,
   output msh_pkg::msh_rec_type    rec_new,
   output msh_pkg::msh_result_type result
);
   import msh_pkg::*;

   logic signed [16:0] max_s;
   logic signed [16:0] height_s;
   logic               in_range;

   // set command terms
   logic [31:0]        rev_diff;
   logic               rev_newer;
   logic signed [16:0] set_diff;
   logic [16:0]        set_dist;
   logic               special;

   // tick terms
   logic               pos_bad, tgt_bad, phase_bad, repaired;
   logic signed [15:0] pos_r, tgt_r;
   logic [2:0]         phase_r;
   logic signed [16:0] tick_diff;
   logic [16:0]        tick_dist;
   logic [1:0]         step_raw, step_eff;
   logic [7:0]         pace_dec, hold_dec;
   logic [1:0]         held_dec, move;
   logic               blocked, go, tick_on;
   logic [3:0]         phase_up, phase_dn;
   msh_rec_type        tick_rec;
   logic [3:0]         coil_sel;

   assign max_s    = $signed({2'b00, cfg.max_steps});
   assign height_s = $signed({item.height[15], item.height});
   assign in_range = (int'(item.stepper_index) < STEPPERS);

   // set: revision order, move size and special heights
   assign rev_diff  = item.revision - rec_old.last_revision;
   assign rev_newer = (rev_diff != 32'd0) && !rev_diff[31];
   assign set_diff  = $signed({rec_old.position[15], rec_old.position}) - height_s;
   assign set_dist  = set_diff[16] ? 17'(-set_diff) : 17'(set_diff);
   assign special   = (item.height == 16'sd0) || (height_s == max_s) || item.height_round;

   // tick: repair of out-of-range values
   assign pos_bad   = rec_old.position[15] ||
                      ($signed({rec_old.position[15], rec_old.position}) > max_s);
   assign tgt_bad   = rec_old.target[15] ||
                      ($signed({rec_old.target[15], rec_old.target}) > max_s);
   assign phase_bad = ({1'b0, rec_old.phase} >= 4'(PHASES));
   assign repaired  = !item.busy_req && (pos_bad || tgt_bad || phase_bad);
   assign pos_r     = (!item.busy_req && pos_bad) ? 16'sd0 : rec_old.position;
   assign tgt_r     = (!item.busy_req && tgt_bad) ? 16'sd0 : rec_old.target;
   assign phase_r   = (!item.busy_req && phase_bad) ? 3'd0 : rec_old.phase;

   // tick: distance to target and step size
   assign tick_diff = $signed({pos_r[15], pos_r}) - $signed({tgt_r[15], tgt_r});
   assign tick_dist = tick_diff[16] ? 17'(-tick_diff) : 17'(tick_diff);

   always_comb begin
      step_raw = 2'd0;
      if (tick_dist != 17'd0) begin
         if (cfg.step_mode == MODE_MIXED) begin
            step_raw = (tick_dist < 17'(FULL_STEP)) ? tick_dist[1:0] : 2'(FULL_STEP);
         end else if (tick_dist >= {15'b0, cfg.step_mode}) begin
            step_raw = cfg.step_mode;
         end
      end
      if (item.busy_req && (step_raw > MODE_HALF)) begin
         step_raw = MODE_HALF;
      end
   end

   // tick: pacing, direction hold and direction of travel
   assign pace_dec = (rec_old.pace_count != 8'd0) ? rec_old.pace_count - 8'd1 : 8'd0;
   assign hold_dec = (rec_old.hold_count != 8'd0) ? rec_old.hold_count - 8'd1 : 8'd0;
   assign held_dec = (rec_old.hold_count == 8'd1) ? DIR_NONE : rec_old.held_direction;

   always_comb begin
      if (tgt_r < pos_r) begin
         move = DIR_DOWN;
      end else if (tgt_r > pos_r) begin
         move = DIR_UP;
      end else begin
         move = DIR_NONE;
      end
   end

   assign blocked  = (rec_old.pace_count != 8'd0) ||
                     ((held_dec != DIR_NONE) && (held_dec != move));
   assign go       = (step_raw != 2'd0) && !blocked;
   // a full step from an odd phase becomes a half step
   assign step_eff = ((step_raw == 2'(FULL_STEP)) && phase_r[0]) ? 2'd1 : step_raw;

   // phase advance modulo the phase count
   always_comb begin
      phase_up = {1'b0, phase_r} + {2'b00, step_eff};
      if (phase_up >= 4'(PHASES)) begin
         phase_up = phase_up - 4'(PHASES);
      end
      if ({1'b0, phase_r} >= {2'b00, step_eff}) begin
         phase_dn = {1'b0, phase_r} - {2'b00, step_eff};
      end else begin
         phase_dn = {1'b0, phase_r} + 4'(PHASES) - {2'b00, step_eff};
      end
   end

   // tick record update, step or brake
   always_comb begin
      tick_rec                = rec_old;
      tick_rec.position       = pos_r;
      tick_rec.target         = tgt_r;
      tick_rec.phase          = phase_r;
      tick_rec.pace_count     = pace_dec;
      tick_rec.held_direction = held_dec;
      tick_rec.hold_count     = hold_dec;
      tick_on                 = 1'b0;
      if (go) begin
         if (move == DIR_DOWN) begin
            tick_rec.position = pos_r - $signed({14'b0, step_eff});
            tick_rec.phase    = phase_dn[2:0];
         end else begin
            tick_rec.position = pos_r + $signed({14'b0, step_eff});
            tick_rec.phase    = phase_up[2:0];
         end
         tick_rec.pace_count     = rec_old.pace_reload;
         tick_rec.brake_count    = 8'd0;
         tick_rec.held_direction = move;
         tick_rec.hold_count     = cfg.turn_wait_time;
         tick_on                 = 1'b1;
      end else if (cfg.brake_mode == BRAKE_SMART) begin
         if (rec_old.brake_count < cfg.brake_ticks) begin
            tick_on              = 1'b1;
            tick_rec.brake_count = rec_old.brake_count + 8'd1;
         end
      end else if (cfg.brake_mode == BRAKE_ALWAYS) begin
         tick_on = 1'b1;
      end
   end

   assign coil_sel = cfg.coil_patterns[{tick_rec.phase, 2'b00} +: 4];

   // op dispatch
   always_comb begin
      rec_new          = rec_old;
      result.out_index = item.stepper_index;
      result.drive     = 1'b0;
      result.coil      = 4'd0;
      result.status    = STATUS_OK;
      case (item.op)
         OP_SET: begin
            if (height_s > max_s) begin
               result.status = STATUS_BAD_HEIGHT;
            end else if (!rev_newer) begin
               result.status = STATUS_STALE;
            end else begin
               rec_new.last_revision = item.revision;
               if (special || (set_dist >= {2'b00, cfg.min_step_delta})) begin
                  rec_new.target      = item.height;
                  rec_new.pace_count  = 8'd0;
                  rec_new.pace_reload = item.wait_ticks;
               end else begin
                  result.status = STATUS_SMALL;
               end
            end
         end
         OP_FORCE: begin
            rec_new.position      = 16'sd0;
            rec_new.pace_count    = 8'd0;
            rec_new.pace_reload   = 8'd0;
            rec_new.brake_count   = 8'd0;
            rec_new.last_revision = item.revision;
            rec_new.target        = item.height;
         end
         OP_STOP: begin
            rec_new.target     = rec_old.position;
            rec_new.pace_count = 8'd0;
         end
         OP_TICK: begin
            rec_new       = tick_rec;
            result.drive  = tick_on;
            result.coil   = tick_on ? coil_sel : 4'd0;
            result.status = repaired ? STATUS_REPAIRED : STATUS_OK;
         end
         default: rec_new = rec_old;
      endcase
      // an index past the stepper count leaves every record alone
      if (!in_range) begin
         rec_new       = rec_old;
         result.drive  = 1'b0;
         result.coil   = 4'd0;
         result.status = STATUS_OK;
      end
   end

endmodule

/* rtl/multi_stepper_halfstep_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stepper_halfstep_engine: many-stepper half-step sequencer
// Per-stepper records live in one memory; each item reads its stepper's
// record, updates it and writes it back, and yields one result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                      | content
//  req     | in  | valid/ready                    | op, index, revision, height, wait, busy
//  rsp     | out | valid/ready                    | index, drive, coil, status
//  csr     | in  | psel/penable/pwrite, pready=1  | seven registers at byte address 4*i
//
//  An item's record is read in the accept cycle; update and write-back follow in
//  the execute state. The single memory read-modify-write sets this order.
//  The result sits in an output register; the next item is taken while it waits.
//  A stalled result channel holds the update cycle until the register frees.
//  Reset is synchronous; record valid bits clear together, so items are
//  taken right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module multi_stepper_halfstep_engine (
   input  logic                           clock,
   input  logic                           reset,
   msh_req_if.sink                        req,
   msh_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [msh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import msh_pkg::*;

   msh_state_type  state_ff, state_in;
   msh_cfg_type    cfg;
   msh_item_type   item_ff, item_in;
   msh_rec_type    rec_old, rec_new;
   msh_result_type result, rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_ready;
   logic           accept;
   logic           slot_free;
   logic           wr_en;

   // divisibility of |height| by the special step, formed at accept
   logic [15:0]                         height_abs;
   logic [SPECIAL_SHIFT+16:0]           round_prod;
   logic                                height_round;

   // configuration registers
   msh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // record memory
   msh_state_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(req.stepper_index)),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(item_ff.stepper_index)),
      .wr_data (rec_new),
      .rd_data (rec_old)
   );

   // record update
   msh_update u_update (
      .cfg     (cfg),
      .item    (item_ff),
      .rec_old (rec_old),
      .rec_new (rec_new),
      .result  (result)
   );

   assign accept    = req.valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: if (accept) state_in = SEQ_EXEC;
         SEQ_EXEC: if (slot_free) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         SEQ_IDLE: req_ready = !reset;
         SEQ_EXEC: wr_en     = slot_free;
         default: begin
            req_ready = 1'b0;
            wr_en     = 1'b0;
         end
      endcase
   end

   assign req.ready = req_ready;

   // reciprocal multiply for the special-height test
   assign height_abs   = req.height[15] ? 16'(-req.height) : 16'(req.height);
   assign round_prod   = {{(SPECIAL_SHIFT+1){1'b0}}, height_abs} *
                         (SPECIAL_SHIFT+17)'(SPECIAL_MUL);
   assign height_round = (round_prod[SPECIAL_SHIFT-1:0] < SPECIAL_SHIFT'(SPECIAL_MUL));

   // item capture on transfer
   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.op            = msh_op_type'(req.op);
         item_in.stepper_index = req.stepper_index;
         item_in.revision      = req.revision;
         item_in.height        = req.height;
         item_in.wait_ticks    = req.wait_ticks;
         item_in.busy_req      = req.busy_req;
         item_in.height_round  = height_round;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // result register
   assign rsp_valid_in = wr_en ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_index = rsp_ff.out_index;
   assign rsp.drive     = rsp_ff.drive;
   assign rsp.coil      = rsp_ff.coil;
   assign rsp.status    = rsp_ff.status;

endmodule

/* rtl/msh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_checker: port-level checks of the stepper engine
// Watches the item and result channels and the one-item-in-flight rule.
// ----------------------------------------------------------------------------
module msh_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [4:0] req_stepper_index,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_out_index,
   input logic       rsp_drive,
   input logic [3:0] rsp_coil,
   input logic [2:0] rsp_status
);

   // one item in flight: no transfer right after a transfer
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while another is in progress");

   // a fresh result traces back to an item transfer
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching item transfer");

   // the result names the stepper its item addressed
   a_index_echo: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_out_index == $past(req_stepper_index, 2))
      else $error("result index differs from item index");

   // coils idle when not driven
   a_coil_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive |-> rsp_coil == 4'd0)
      else $error("coil pattern shown while not driven");

   // stalled result holds its valid, index and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
                                  && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind multi_stepper_halfstep_engine msh_checker u_msh_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_stepper_index (req.stepper_index),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_index     (rsp.out_index),
   .rsp_drive         (rsp.drive),
   .rsp_coil          (rsp.coil),
   .rsp_status        (rsp.status)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi-stepper half-step engine
// Commands go in through the request channel and coil results are checked
// against a motor-record predictor kept in the bench. A short directed run
// comes first, then random command streams under eight register settings,
// with idling on both channels in all but the last two.
// ----------------------------------------------------------------------------
module tb_top;
   import msh_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int ITEMS_PER_SET = 191;
   localparam int SETTINGS_CNT  = 8;
   localparam int STALL_LIMIT   = 5000;
   localparam int MAX_REPORTS   = 30;

   // one command as queued and as seen on the request channel
   typedef struct packed {
      msh_op_type         op;
      logic [4:0]         idx;
      logic [31:0]        rev;
      logic signed [15:0] height;
      logic [7:0]         wait_ticks;
      logic               busy;
   } motor_cmd_t;

   typedef struct packed {
      logic [4:0]     idx;
      logic           drive;
      logic [3:0]     coil;
      msh_status_type status;
   } coil_result_t;

   typedef struct {
      logic signed [15:0] position;
      logic signed [15:0] target;
      logic [2:0]         phase;
      logic [7:0]         pace_count;
      logic [7:0]         pace_reload;
      logic [7:0]         brake_count;
      logic [1:0]         held_dir;
      logic [7:0]         hold_count;
      logic [31:0]        last_rev;
   } motor_rec_t;

   typedef struct {
      logic [14:0] max_steps;
      logic [14:0] min_delta;
      logic [1:0]  step_mode;
      logic [7:0]  turn_wait;
      logic [1:0]  brake_mode;
      logic [7:0]  brake_ticks;
      logic [31:0] coils;
   } motor_cfg_t;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   msh_req_if req ();
   msh_rsp_if rsp ();

   multi_stepper_halfstep_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench-side copy of the motor records and registers
   motor_rec_t motors [STEPPERS];
   motor_cfg_t cfg;
   motor_cfg_t plan [SETTINGS_CNT];

   motor_cmd_t   pending_cmds [$];
   coil_result_t due_results [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        cmd_taken;
   int          errors;
   int          cmds_sent;
   int          results_seen;
   int          driven_seen;
   int          status_seen [5];
   int          stall_cycles;
   logic [31:0] gen_rev [STEPPERS];

   motor_cmd_t   next_cmd;
   motor_cmd_t   seen_cmd;
   coil_result_t got_res;
   coil_result_t exp_res;

   // clock
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // apply one command to the motor records and return the coil result
   function automatic coil_result_t advance_motor(motor_cmd_t c);
      coil_result_t r;
      motor_rec_t   m;
      int           h;
      int           a;
      int           d;
      int           pos;
      int           tgt;
      int           maxv;
      int           stp;
      logic [31:0]  rdiff;
      logic [1:0]   dir;
      bit           waiting;
      bit           on;
      m = motors[c.idx];
      r.idx = c.idx;
      r.drive = 1'b0;
      r.coil = 4'd0;
      r.status = STATUS_OK;
      h = c.height;
      maxv = int'(cfg.max_steps);
      pos = m.position;
      tgt = m.target;
      case (c.op)
         OP_SET: begin
            rdiff = c.rev - m.last_rev;
            if (h > maxv) begin
               r.status = STATUS_BAD_HEIGHT;
            end else if (rdiff == 32'd0 || rdiff[31]) begin
               r.status = STATUS_STALE;
            end else begin
               d = pos - h;
               if (d < 0) d = -d;
               a = (h < 0) ? -h : h;
               m.last_rev = c.rev;
               if (h == 0 || h == maxv || (a % SPECIAL_STEP) == 0 ||
                   d >= int'(cfg.min_delta)) begin
                  tgt = h;
                  m.pace_count = 8'd0;
                  m.pace_reload = c.wait_ticks;
               end else begin
                  r.status = STATUS_SMALL;
               end
            end
         end
         OP_FORCE: begin
            pos = 0;
            m.pace_count = 8'd0;
            m.pace_reload = 8'd0;
            m.brake_count = 8'd0;
            m.last_rev = c.rev;
            tgt = h;
         end
         OP_STOP: begin
            tgt = pos;
            m.pace_count = 8'd0;
         end
         default: begin
            // repair out-of-range values unless the tick is busy
            if (!c.busy) begin
               if (pos < 0 || pos > maxv) begin
                  pos = 0;
                  r.status = STATUS_REPAIRED;
               end
               if (tgt < 0 || tgt > maxv) begin
                  tgt = 0;
                  r.status = STATUS_REPAIRED;
               end
            end
            // step size from distance and step mode
            d = pos - tgt;
            if (d < 0) d = -d;
            stp = 0;
            if (d != 0) begin
               if (cfg.step_mode == MODE_MIXED) stp = (d < FULL_STEP) ? d : FULL_STEP;
               else if (d >= int'(cfg.step_mode)) stp = int'(cfg.step_mode);
            end
            if (c.busy && stp > 1) stp = 1;
            // pacing and direction hold
            waiting = (m.pace_count > 0);
            if (m.pace_count > 0) m.pace_count = m.pace_count - 8'd1;
            if (m.hold_count > 0) begin
               m.hold_count = m.hold_count - 8'd1;
               if (m.hold_count == 0) m.held_dir = DIR_NONE;
            end
            if (tgt < pos) dir = DIR_DOWN;
            else if (tgt > pos) dir = DIR_UP;
            else dir = DIR_NONE;
            if (m.held_dir != DIR_NONE && m.held_dir != dir) waiting = 1'b1;
            on = 1'b0;
            if (stp > 0 && !waiting) begin
               // odd phase forces a half step
               if ((m.phase % stp) != 0) stp = 1;
               if (dir == DIR_DOWN) begin
                  pos = pos - stp;
                  m.phase = m.phase - stp[2:0];
               end else begin
                  pos = pos + stp;
                  m.phase = m.phase + stp[2:0];
               end
               m.pace_count = m.pace_reload;
               m.brake_count = 8'd0;
               m.held_dir = dir;
               m.hold_count = cfg.turn_wait;
               on = 1'b1;
            end else if (cfg.brake_mode == BRAKE_SMART) begin
               if (m.brake_count < cfg.brake_ticks) begin
                  on = 1'b1;
                  m.brake_count = m.brake_count + 8'd1;
               end
            end else if (cfg.brake_mode == BRAKE_ALWAYS) begin
               on = 1'b1;
            end
            if (on) begin
               r.drive = 1'b1;
               r.coil = cfg.coils[4*m.phase +: 4];
            end
         end
      endcase
      m.position = pos[15:0];
      m.target = tgt[15:0];
      motors[c.idx] = m;
      return r;
   endfunction

   function automatic motor_cmd_t make_cmd(msh_op_type op, int unsigned idx,
                                           logic [31:0] rev, int h,
                                           int unsigned w, bit busy);
      motor_cmd_t c;
      c.op = op;
      c.idx = idx[4:0];
      c.rev = rev;
      c.height = h[15:0];
      c.wait_ticks = w[7:0];
      c.busy = busy;
      return c;
   endfunction

   // register write: setup cycle, then access cycle
   task automatic write_reg(msh_reg_type r, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         REG_MAX_STEPS:      cfg.max_steps = val[14:0];
         REG_MIN_STEP_DELTA: cfg.min_delta = val[14:0];
         REG_STEP_MODE:      cfg.step_mode = val[1:0];
         REG_TURN_WAIT:      cfg.turn_wait = val[7:0];
         REG_BRAKE_MODE:     cfg.brake_mode = val[1:0];
         REG_BRAKE_TICKS:    cfg.brake_ticks = val[7:0];
         default:            cfg.coils = val;
      endcase
   endtask

   task automatic write_setting(motor_cfg_t s);
      write_reg(REG_MAX_STEPS, {17'd0, s.max_steps});
      write_reg(REG_MIN_STEP_DELTA, {17'd0, s.min_delta});
      write_reg(REG_STEP_MODE, {30'd0, s.step_mode});
      write_reg(REG_TURN_WAIT, {24'd0, s.turn_wait});
      write_reg(REG_BRAKE_MODE, {30'd0, s.brake_mode});
      write_reg(REG_BRAKE_TICKS, {24'd0, s.brake_ticks});
      write_reg(REG_COIL_PATTERNS, s.coils);
   endtask

   // hold off until every queued command has come back as a result
   task automatic drain_all();
      while (pending_cmds.size() != 0 || req.valid || due_results.size() != 0)
         @(posedge clock);
   endtask

   // random commands: mostly set-then-tick traffic on a few motors
   task automatic queue_random_cmds(int n);
      int          sel;
      int          lim;
      int          h;
      int unsigned idx;
      int unsigned w;
      logic [31:0] rev;
      msh_op_type  op;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 22) op = OP_SET;
         else if (sel < 26) op = OP_FORCE;
         else if (sel < 30) op = OP_STOP;
         else op = OP_TICK;
         idx = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(31);
         // heights near the motor range, with special and bad values mixed in
         lim = (int'(cfg.max_steps) < 60) ? int'(cfg.max_steps) : 60;
         sel = $urandom_range(99);
         if (sel < 60) h = $urandom_range(lim);
         else if (sel < 72) h = SPECIAL_STEP * $urandom_range(3);
         else if (sel < 80) h = int'(cfg.max_steps);
         else if (sel < 86) h = -int'($urandom_range(50, 1));
         else if (sel < 91) h = int'(cfg.max_steps) + int'($urandom_range(20, 1));
         else h = $urandom();
         // revisions mostly move forward, some repeat, some jump anywhere
         sel = $urandom_range(99);
         if (sel < 85) begin
            rev = gen_rev[idx] + $urandom_range(3, 1);
            if (op == OP_SET || op == OP_FORCE) gen_rev[idx] = rev;
         end else if (sel < 92) begin
            rev = gen_rev[idx];
         end else begin
            rev = $urandom();
            if (op == OP_FORCE) gen_rev[idx] = rev;
         end
         sel = $urandom_range(99);
         if (sel < 70) w = $urandom_range(2);
         else if (sel < 90) w = $urandom_range(10, 3);
         else w = $urandom_range(255);
         pending_cmds.push_back(make_cmd(op, idx, rev, h, w, $urandom_range(99) < 15));
      end
   endtask

   // request driver: loads the next command once the current one transfers
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || cmd_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = pending_cmds.pop_front();
            req.valid <= 1'b1;
            req.op <= next_cmd.op;
            req.stepper_index <= next_cmd.idx;
            req.revision <= next_cmd.rev;
            req.height <= next_cmd.height;
            req.wait_ticks <= next_cmd.wait_ticks;
            req.busy_req <= next_cmd.busy;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // request transfer: predict the result of the accepted command
   always @(posedge clock) begin
      cmd_taken <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         seen_cmd.op = msh_op_type'(req.op);
         seen_cmd.idx = req.stepper_index;
         seen_cmd.rev = req.revision;
         seen_cmd.height = req.height;
         seen_cmd.wait_ticks = req.wait_ticks;
         seen_cmd.busy = req.busy_req;
         due_results.push_back(advance_motor(seen_cmd));
         cmds_sent <= cmds_sent + 1;
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         got_res.idx = rsp.out_index;
         got_res.drive = rsp.drive;
         got_res.coil = rsp.coil;
         got_res.status = msh_status_type'(rsp.status);
         results_seen <= results_seen + 1;
         if (got_res.drive === 1'b1) driven_seen <= driven_seen + 1;
         if (got_res.status <= STATUS_REPAIRED)
            status_seen[got_res.status] <= status_seen[got_res.status] + 1;
         if (due_results.size() == 0) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
               $display("%0t: unexpected result idx=%0d drive=%0b coil=%h status=%0d",
                        $time, got_res.idx, got_res.drive, got_res.coil, got_res.status);
         end else begin
            exp_res = due_results.pop_front();
            if (got_res.idx !== exp_res.idx || got_res.drive !== exp_res.drive ||
                got_res.coil !== exp_res.coil || got_res.status !== exp_res.status) begin
               errors <= errors + 1;
               if (errors < MAX_REPORTS)
                  $display("%0t: exp idx/drive/coil/status %0d/%0b/%h/%0d, got %0d/%0b/%h/%0d",
                           $time, exp_res.idx, exp_res.drive, exp_res.coil,
                           exp_res.status, got_res.idx, got_res.drive,
                           got_res.coil, got_res.status);
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = OP_TICK;
      req.stepper_index = '0;
      req.revision = '0;
      req.height = '0;
      req.wait_ticks = '0;
      req.busy_req = 1'b0;
      rsp.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cmd_taken = 1'b0;
      errors = 0;
      cmds_sent = 0;
      results_seen = 0;
      driven_seen = 0;
      stall_cycles = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (motors[i]) begin
         motors[i] = '{default: '0};
         gen_rev[i] = 32'd0;
      end
      cfg.max_steps = MAX_STEPS_RST;
      cfg.min_delta = MIN_STEP_DELTA_RST;
      cfg.step_mode = STEP_MODE_RST;
      cfg.turn_wait = TURN_WAIT_RST;
      cfg.brake_mode = BRAKE_MODE_RST;
      cfg.brake_ticks = BRAKE_TICKS_RST;
      cfg.coils = COIL_PATTERNS_RST;

      // register settings for the random part, extremes included
      plan[0] = '{15'd200,   15'd0,     MODE_HALF,  8'd3,   BRAKE_SMART,  8'd4,   $urandom()};
      plan[1] = '{15'd100,   15'd3,     MODE_FULL,  8'd0,   BRAKE_ALWAYS, 8'd0,   32'hFFFF_FFFF};
      plan[2] = '{15'd32767, 15'd32767, MODE_MIXED, 8'd255, BRAKE_SMART,  8'd255, 32'h0};
      plan[3] = '{15'd0,     15'd0,     2'd0,       8'd1,   2'd3,         8'd10,  $urandom()};
      plan[4] = '{15'd150,   15'd1,     MODE_MIXED, 8'd5,   BRAKE_SMART,  8'd2,   $urandom()};
      plan[5] = '{15'd250,   15'd10,    MODE_FULL,  8'd2,   BRAKE_ALWAYS, 8'd7,   $urandom()};
      plan[6] = '{15'd80,    15'd0,     MODE_HALF,  8'd0,   BRAKE_NONE,   8'd1,   $urandom()};
      plan[7] = '{15'd300,   15'd2,     MODE_MIXED, 8'd4,   BRAKE_SMART,  8'd255, $urandom()};

      send_idle_pct = 7;
      recv_idle_pct = 50;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every op, revision edges, bad and negative heights, reversal
      pending_cmds.push_back(make_cmd(OP_TICK, 0, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 0, 32'd1, 6, 0, 0));
      repeat (6) pending_cmds.push_back(make_cmd(OP_TICK, 0, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 32'h8000_0000, 10, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 32'h7FFF_FFFF, 32767, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 32'h7FFF_FFFF, 8000, 255, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 1, 32'h7FFF_FFFF, 100, 0, 0));
      pending_cmds.push_back(make_cmd(OP_FORCE, 31, 32'hFFFF_FFFF, -32768, 255, 1));
      pending_cmds.push_back(make_cmd(OP_TICK, 31, 32'hFFFF_FFFF, -1, 255, 1));
      pending_cmds.push_back(make_cmd(OP_TICK, 31, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 2, 32'd5, -1, 1, 0));
      pending_cmds.push_back(make_cmd(OP_TICK, 2, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_SET, 0, 32'd2, 0, 3, 0));
      repeat (4) pending_cmds.push_back(make_cmd(OP_TICK, 0, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_STOP, 0, 32'd0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, 32'd0, 0, 0, 1));
      gen_rev[0] = 32'd2;
      gen_rev[1] = 32'h7FFF_FFFF;
      gen_rev[2] = 32'd5;
      gen_rev[31] = 32'hFFFF_FFFF;
      drain_all();

      // random part, one register setting at a time
      for (int k = 0; k < SETTINGS_CNT; k++) begin
         if (k == 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 7;
         end else if (k == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_setting(plan[k]);
         queue_random_cmds(ITEMS_PER_SET);
         drain_all();
      end

      repeat (8) @(posedge clock);
      $display("run covered %0d commands under %0d register settings, %0d results checked",
               cmds_sent, SETTINGS_CNT + 1, results_seen);
      $display("driven %0d; status ok %0d, bad height %0d, stale %0d, small %0d, repaired %0d",
               driven_seen, status_seen[STATUS_OK], status_seen[STATUS_BAD_HEIGHT],
               status_seen[STATUS_STALE], status_seen[STATUS_SMALL],
               status_seen[STATUS_REPAIRED]);
      if (errors == 0 && due_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/msh_pkg.sv
rtl/msh_if.sv
rtl/msh_csr.sv
rtl/msh_state_ram.sv
rtl/msh_update.sv
rtl/multi_stepper_halfstep_engine.sv
rtl/msh_checker.sv
dv/tb_top.sv
